/* design/adnd_pkg.sv */
// Package for the ADPCM nibble decoder: types, action codes, step and index tables.
package adnd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 7;
    localparam logic [INDEX_W-1:0] MAX_INDEX = 7'd88;
    localparam logic signed [17:0] SAT_POS = 18'sh07FFF;
    localparam logic signed [17:0] SAT_NEG = -18'sh07FFF;

    typedef enum logic [1:0] {
        ACT_HEADER  = 2'd0,
        ACT_DECODE  = 2'd1,
        ACT_RESTORE = 2'd2
    } action_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] header_word;
        logic [7:0]  data_byte;
        logic        high_nibble;
        logic        save_loop;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] predictor;
        logic [INDEX_W-1:0]         index;
        logic signed [SAMPLE_W-1:0] loop_predictor;
        logic [INDEX_W-1:0]         loop_index;
    } dec_state_t;

    function automatic logic signed [7:0] index_adjust(input logic [2:0] code);
        logic signed [7:0] adj;
        case (code)
            3'd4:    adj = 8'sd2;
            3'd5:    adj = 8'sd4;
            3'd6:    adj = 8'sd6;
            3'd7:    adj = 8'sd8;
            default: adj = -8'sd1;
        endcase
        return adj;
    endfunction

    function automatic logic [15:0] step_lookup(input logic [INDEX_W-1:0] idx);
        logic [15:0] s;
        case (idx)
            7'd0:  s = 16'h0007; 7'd1:  s = 16'h0008; 7'd2:  s = 16'h0009; 7'd3:  s = 16'h000A;
            7'd4:  s = 16'h000B; 7'd5:  s = 16'h000C; 7'd6:  s = 16'h000D; 7'd7:  s = 16'h000E;
            7'd8:  s = 16'h0010; 7'd9:  s = 16'h0011; 7'd10: s = 16'h0013; 7'd11: s = 16'h0015;
            7'd12: s = 16'h0017; 7'd13: s = 16'h0019; 7'd14: s = 16'h001C; 7'd15: s = 16'h001F;
            7'd16: s = 16'h0022; 7'd17: s = 16'h0025; 7'd18: s = 16'h0029; 7'd19: s = 16'h002D;
            7'd20: s = 16'h0032; 7'd21: s = 16'h0037; 7'd22: s = 16'h003C; 7'd23: s = 16'h0042;
            7'd24: s = 16'h0049; 7'd25: s = 16'h0050; 7'd26: s = 16'h0058; 7'd27: s = 16'h0061;
            7'd28: s = 16'h006B; 7'd29: s = 16'h0076; 7'd30: s = 16'h0082; 7'd31: s = 16'h008F;
            7'd32: s = 16'h009D; 7'd33: s = 16'h00AD; 7'd34: s = 16'h00BE; 7'd35: s = 16'h00D1;
            7'd36: s = 16'h00E6; 7'd37: s = 16'h00FD; 7'd38: s = 16'h0117; 7'd39: s = 16'h0133;
            7'd40: s = 16'h0151; 7'd41: s = 16'h0173; 7'd42: s = 16'h0198; 7'd43: s = 16'h01C1;
            7'd44: s = 16'h01EE; 7'd45: s = 16'h0220; 7'd46: s = 16'h0256; 7'd47: s = 16'h0292;
            7'd48: s = 16'h02D4; 7'd49: s = 16'h031C; 7'd50: s = 16'h036C; 7'd51: s = 16'h03C3;
            7'd52: s = 16'h0424; 7'd53: s = 16'h048E; 7'd54: s = 16'h0502; 7'd55: s = 16'h0583;
            7'd56: s = 16'h0610; 7'd57: s = 16'h06AB; 7'd58: s = 16'h0756; 7'd59: s = 16'h0812;
            7'd60: s = 16'h08E0; 7'd61: s = 16'h09C3; 7'd62: s = 16'h0ABD; 7'd63: s = 16'h0BD0;
            7'd64: s = 16'h0CFF; 7'd65: s = 16'h0E4C; 7'd66: s = 16'h0FBA; 7'd67: s = 16'h114C;
            7'd68: s = 16'h1307; 7'd69: s = 16'h14EE; 7'd70: s = 16'h1706; 7'd71: s = 16'h1954;
            7'd72: s = 16'h1BDC; 7'd73: s = 16'h1EA5; 7'd74: s = 16'h21B6; 7'd75: s = 16'h2515;
            7'd76: s = 16'h28CA; 7'd77: s = 16'h2CDF; 7'd78: s = 16'h315B; 7'd79: s = 16'h364B;
            7'd80: s = 16'h3BB9; 7'd81: s = 16'h41B2; 7'd82: s = 16'h4844; 7'd83: s = 16'h4F7E;
            7'd84: s = 16'h5771; 7'd85: s = 16'h602F; 7'd86: s = 16'h69CE; 7'd87: s = 16'h7462;
            default: s = 16'h7FFF;
        endcase
        return s;
    endfunction

endpackage

/* design/adnd_core.sv */
// Next-state logic of the ADPCM nibble decoder for one item.
module adnd_core
    import adnd_pkg::*;
(
    input  item_t      item,
    input  dec_state_t cur,
    output dec_state_t nxt
);

    logic [3:0]         code;
    logic [INDEX_W-1:0] idx;
    logic [15:0]        step;
    logic [17:0]        diff;
    logic signed [17:0] pred_wide;
    logic signed [17:0] pred_sum;
    logic signed [17:0] pred_sat;
    logic signed [7:0]  idx_sum;
    logic [INDEX_W-1:0] idx_new;
    logic [7:0]         hdr_idx;
    logic [INDEX_W-1:0] hdr_idx_sat;

    always_comb
    begin
        code = item.high_nibble ? item.data_byte[7:4] : item.data_byte[3:0];
        idx  = (cur.index > MAX_INDEX) ? MAX_INDEX : cur.index;
        step = step_lookup(idx);

        diff = {5'd0, step[15:3]};
        if (code[0])
        begin
            diff = diff + {4'd0, step[15:2]};
        end
        if (code[1])
        begin
            diff = diff + {3'd0, step[15:1]};
        end
        if (code[2])
        begin
            diff = diff + {2'd0, step};
        end

        pred_wide = {{2{cur.predictor[SAMPLE_W-1]}}, cur.predictor};
        if (code[3])
        begin
            pred_sum = pred_wide - $signed(diff);
            pred_sat = (pred_sum < SAT_NEG) ? SAT_NEG : pred_sum;
        end
        else
        begin
            pred_sum = pred_wide + $signed(diff);
            pred_sat = (pred_sum > SAT_POS) ? SAT_POS : pred_sum;
        end

        idx_sum = $signed({1'b0, idx}) + index_adjust(code[2:0]);
        if (idx_sum < 8'sd0)
        begin
            idx_new = '0;
        end
        else if (idx_sum > $signed({1'b0, MAX_INDEX}))
        begin
            idx_new = MAX_INDEX;
        end
        else
        begin
            idx_new = idx_sum[INDEX_W-1:0];
        end

        hdr_idx     = item.header_word[23:16];
        hdr_idx_sat = (hdr_idx > {1'b0, MAX_INDEX}) ? MAX_INDEX : hdr_idx[INDEX_W-1:0];

        nxt = cur;
        case (action_t'(item.action))
            ACT_HEADER:
            begin
                nxt.predictor      = item.header_word[15:0];
                nxt.index          = hdr_idx_sat;
                nxt.loop_predictor = item.header_word[15:0];
                nxt.loop_index     = hdr_idx_sat;
            end
            ACT_DECODE:
            begin
                nxt.predictor = pred_sat[SAMPLE_W-1:0];
                nxt.index     = idx_new;
                if (item.save_loop)
                begin
                    nxt.loop_predictor = pred_sat[SAMPLE_W-1:0];
                    nxt.loop_index     = idx_new;
                end
            end
            ACT_RESTORE:
            begin
                nxt.predictor = cur.loop_predictor;
                nxt.index     = cur.loop_index;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

/* design/adpcm_nibble_decoder_top.sv */
// Top level of the ADPCM nibble decoder: input register, decoder state and result register.
//
// Channel  Dir  tdata (low bit up)                                          tuser
// s_axis   in   header_word[31:0] data_byte[39:32] high_nibble[40]
//               save_loop[41], zero[47:42]                                  action[1:0]
// m_axis   out  sample[15:0] step_index[22:16], zero[23]                    -
//
// One item per cycle sustained while m_axis_tready stays high; each item's result is registered.
// The item register feeds the step-table lookup, add and clamp into the result register.
// Reset clears decoder state, loop state and both valid flags.
// A stalled result holds in the output register while one more item waits in the
// item register; s_axis_tready drops only when both are full.
module adpcm_nibble_decoder_top
    import adnd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // header_word, data_byte, high_nibble, save_loop
    input  logic [1:0]  s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // sample, step_index
);

    item_t      item_reg;
    logic       item_valid_reg;
    dec_state_t state_reg;
    dec_state_t state_next;
    logic [23:0] out_data_reg;
    logic       out_valid_reg;
    logic       advance;
    logic       accept;

    assign advance       = item_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !item_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    adnd_core u_core
    (
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.action      <= s_axis_tuser;
            item_reg.header_word <= s_axis_tdata[31:0];
            item_reg.data_byte   <= s_axis_tdata[39:32];
            item_reg.high_nibble <= s_axis_tdata[40];
            item_reg.save_loop   <= s_axis_tdata[41];
        end
        if (advance)
        begin
            out_data_reg <= {1'b0, state_next.index, state_next.predictor};
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the ADPCM nibble decoder: stream driver, result monitor and state predictor.
`timescale 1ns / 1ps

module tb_top
    import adnd_pkg::*;
();

    localparam int LIMIT = 200000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 450;

    localparam logic [89*16-1:0] STEP_ROM = {
        16'h0007, 16'h0008, 16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h000E,
        16'h0010, 16'h0011, 16'h0013, 16'h0015, 16'h0017, 16'h0019, 16'h001C, 16'h001F,
        16'h0022, 16'h0025, 16'h0029, 16'h002D, 16'h0032, 16'h0037, 16'h003C, 16'h0042,
        16'h0049, 16'h0050, 16'h0058, 16'h0061, 16'h006B, 16'h0076, 16'h0082, 16'h008F,
        16'h009D, 16'h00AD, 16'h00BE, 16'h00D1, 16'h00E6, 16'h00FD, 16'h0117, 16'h0133,
        16'h0151, 16'h0173, 16'h0198, 16'h01C1, 16'h01EE, 16'h0220, 16'h0256, 16'h0292,
        16'h02D4, 16'h031C, 16'h036C, 16'h03C3, 16'h0424, 16'h048E, 16'h0502, 16'h0583,
        16'h0610, 16'h06AB, 16'h0756, 16'h0812, 16'h08E0, 16'h09C3, 16'h0ABD, 16'h0BD0,
        16'h0CFF, 16'h0E4C, 16'h0FBA, 16'h114C, 16'h1307, 16'h14EE, 16'h1706, 16'h1954,
        16'h1BDC, 16'h1EA5, 16'h21B6, 16'h2515, 16'h28CA, 16'h2CDF, 16'h315B, 16'h364B,
        16'h3BB9, 16'h41B2, 16'h4844, 16'h4F7E, 16'h5771, 16'h602F, 16'h69CE, 16'h7462,
        16'h7FFF
    };

    typedef struct {
        item_t item;
        bit    drain;
    } pending_t;

    typedef struct {
        logic signed [15:0] sample;
        logic [6:0]         index;
    } dec_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    pending_t    pending_items[$];
    dec_result_t expected_results[$];
    pending_t    offered;
    bit          item_taken = 1'b0;

    logic signed [15:0] pred_q = '0;
    logic [6:0]         index_q = '0;
    logic signed [15:0] loop_pred_q = '0;
    logic [6:0]         loop_index_q = '0;

    int accepted_n = 0;
    int checked_n = 0;
    int errors = 0;
    int cycle_n = 0;
    int sat_hi_n = 0;
    int sat_lo_n = 0;
    int action_n[4] = '{0, 0, 0, 0};
    int hold_cnt = 0;
    bit hold_done = 1'b0;

    adpcm_nibble_decoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    function automatic bit no_idle();
        return accepted_n >= 260 && accepted_n < 340;
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    function automatic bit rnd1();
        return 1'($urandom);
    endfunction

    function automatic int step_size(input logic [6:0] idx);
        return int'(STEP_ROM[(88 - int'(idx))*16 +: 16]);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at result %0d: %s", checked_n, msg);
        errors++;
    endtask

    task automatic queue_item(input logic [1:0] act, input logic [31:0] hdr,
                              input logic [7:0] byt, input bit hi, input bit sv,
                              input bit drn);
        pending_t p;
        p.item.action      = act;
        p.item.header_word = hdr;
        p.item.data_byte   = byt;
        p.item.high_nibble = hi;
        p.item.save_loop   = sv;
        p.drain            = drn;
        pending_items.push_back(p);
    endtask

    task automatic adpcm_predict(input item_t it);
        dec_result_t r;
        logic [3:0]  code;
        int          step;
        int          diff;
        int          acc;
        int          ni;
        if (it.action == ACT_HEADER)
        begin
            pred_q = it.header_word[15:0];
            index_q = (it.header_word[23:16] > 8'd88) ? MAX_INDEX : it.header_word[22:16];
            loop_pred_q = pred_q;
            loop_index_q = index_q;
        end
        else if (it.action == ACT_DECODE)
        begin
            code = it.high_nibble ? it.data_byte[7:4] : it.data_byte[3:0];
            step = step_size(index_q);
            diff = step >> 3;
            if (code[0]) diff += step >> 2;
            if (code[1]) diff += step >> 1;
            if (code[2]) diff += step;
            acc = int'(pred_q);
            if (code[3])
            begin
                acc -= diff;
                if (acc < -32767)
                begin
                    acc = -32767;
                    sat_lo_n++;
                end
            end
            else
            begin
                acc += diff;
                if (acc > 32767)
                begin
                    acc = 32767;
                    sat_hi_n++;
                end
            end
            ni = int'(index_q) + (code[2] ? 2 * (int'(code[1:0]) + 1) : -1);
            if (ni < 0) ni = 0;
            if (ni > 88) ni = 88;
            pred_q = 16'(acc);
            index_q = 7'(ni);
            if (it.save_loop)
            begin
                loop_pred_q = pred_q;
                loop_index_q = index_q;
            end
        end
        else if (it.action == ACT_RESTORE)
        begin
            pred_q = loop_pred_q;
            index_q = loop_index_q;
        end
        r.sample = pred_q;
        r.index = index_q;
        expected_results.push_back(r);
    endtask

    always @(posedge clk)
    begin
        dec_result_t want;
        logic signed [15:0] got_sample;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_sample = m_axis_tdata[15:0];
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result sample %0d index %0d",
                                          got_sample, m_axis_tdata[22:16]));
            end
            else
            begin
                want = expected_results.pop_front();
                if (got_sample !== want.sample)
                    report_mismatch($sformatf("sample got %0d expected %0d",
                                              got_sample, want.sample));
                if (m_axis_tdata[22:16] !== want.index)
                    report_mismatch($sformatf("step_index got %0d expected %0d",
                                              m_axis_tdata[22:16], want.index));
            end
            checked_n++;
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            adpcm_predict(offered.item);
            action_n[offered.item.action]++;
            accepted_n++;
            item_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || item_taken))
        begin
            item_taken = 1'b0;
            if (pending_items.size() == 0
                || (pending_items[0].drain && expected_results.size() != 0)
                || (!no_idle() && $urandom_range(0, 99) < 31))
            begin
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                offered = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {6'b0, offered.item.save_loop, offered.item.high_nibble,
                                 offered.item.data_byte, offered.item.header_word};
                s_axis_tuser <= offered.item.action;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && accepted_n >= 120)
            begin
                hold_done = 1'b1;
                hold_cnt = 80;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end
            else if (no_idle())
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= 31);
        end
    end

    initial
    begin
        while (cycle_n < LIMIT) @(posedge clk) cycle_n++;
        $display("Timeout after %0d cycles, %0d results outstanding", cycle_n,
                 expected_results.size());
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int          n_rand;
        int          run_len;
        logic [31:0] hdr;
        queue_item(ACT_HEADER,  32'h0000_0000, rnd8(),   rnd1(),   rnd1(),   1'b0);
        queue_item(ACT_DECODE,  $urandom,      8'hA3,    1'b0,     1'b0,     1'b0);
        queue_item(ACT_HEADER,  32'hFF59_7FFF, rnd8(),   rnd1(),   rnd1(),   1'b0);
        queue_item(ACT_DECODE,  $urandom,      8'h70,    1'b1,     1'b0,     1'b0);
        queue_item(ACT_DECODE,  $urandom,      8'h5F,    1'b0,     1'b0,     1'b0);
        queue_item(ACT_HEADER,  32'h0000_8000, rnd8(),   rnd1(),   rnd1(),   1'b0);
        queue_item(ACT_DECODE,  $urandom,      8'h08,    1'b0,     1'b0,     1'b0);
        queue_item(ACT_HEADER,  32'h0000_8000, rnd8(),   rnd1(),   rnd1(),   1'b0);
        queue_item(ACT_DECODE,  $urandom,      8'h0F,    1'b1,     1'b0,     1'b0);
        queue_item(ACT_HEADER,  32'h0058_8000, rnd8(),   rnd1(),   rnd1(),   1'b0);
        queue_item(ACT_DECODE,  $urandom,      8'hF0,    1'b1,     1'b0,     1'b0);
        queue_item(ACT_HEADER,  32'h0058_0000, rnd8(),   rnd1(),   rnd1(),   1'b0);
        queue_item(ACT_DECODE,  $urandom,      8'hC4,    1'b0,     1'b1,     1'b0);
        queue_item(ACT_DECODE,  $urandom,      8'hC4,    1'b1,     1'b0,     1'b0);
        queue_item(ACT_DECODE,  $urandom,      8'h9E,    1'b0,     1'b0,     1'b0);
        queue_item(ACT_RESTORE, $urandom,      rnd8(),   rnd1(),   rnd1(),   1'b0);
        queue_item(ACT_UNUSED,  $urandom,      rnd8(),   rnd1(),   rnd1(),   1'b0);
        queue_item(ACT_HEADER,  32'h0040_1234, rnd8(),   rnd1(),   rnd1(),   1'b0);
        queue_item(ACT_DECODE,  $urandom,      8'h6B,    1'b1,     1'b0,     1'b0);
        queue_item(ACT_RESTORE, $urandom,      rnd8(),   rnd1(),   rnd1(),   1'b0);
        queue_item(ACT_HEADER,  32'hFFFF_FFFF, rnd8(),   rnd1(),   rnd1(),   1'b0);
        queue_item(ACT_DECODE,  $urandom,      8'h1A,    1'b0,     1'b1,     1'b0);
        queue_item(ACT_HEADER,  32'h0058_7FFF, rnd8(),   rnd1(),   rnd1(),   1'b0);
        queue_item(ACT_DECODE,  $urandom,      8'h2D,    1'b1,     1'b1,     1'b0);

        n_rand = 0;
        while (n_rand < RANDOM_ITEMS)
        begin
            hdr = $urandom;
            if ($urandom_range(0, 99) < 70) hdr[23:16] = 8'($urandom_range(0, 88));
            if ($urandom_range(0, 99) < 8) hdr[15:0] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            queue_item(ACT_HEADER, hdr, rnd8(), rnd1(), rnd1(),
                       n_rand == 0 || $urandom_range(0, 99) < 10);
            n_rand++;
            run_len = $urandom_range(4, 24);
            repeat (run_len)
            begin
                case ($urandom_range(0, 99))
                    0, 1, 2, 3:
                        queue_item(ACT_RESTORE, $urandom, rnd8(), rnd1(), rnd1(), 1'b0);
                    4, 5, 6:
                        queue_item(ACT_UNUSED, $urandom, rnd8(), rnd1(), rnd1(), 1'b0);
                    7, 8:
                        queue_item(ACT_HEADER, $urandom, rnd8(), rnd1(), rnd1(), 1'b0);
                    default:
                        queue_item(ACT_DECODE, $urandom, rnd8(), rnd1(),
                                   $urandom_range(0, 99) < 12, 1'b0);
                endcase
                n_rand++;
            end
            if ($urandom_range(0, 99) < 25)
            begin
                queue_item(ACT_RESTORE, $urandom, rnd8(), rnd1(), rnd1(), rnd1());
                n_rand++;
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || s_axis_tvalid) @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d items: %0d headers, %0d decodes, %0d restores, %0d unused actions",
                 accepted_n, action_n[0], action_n[1], action_n[2], action_n[3]);
        $display("Checked %0d results; predictor clamped %0d times high, %0d times low",
                 checked_n, sat_hi_n, sat_lo_n);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
